FILE: hdl/seg_pkg.sv
// Package for the file packet segmenter: shared types and constants.
// Used by the front, queue, back and top-level modules.
// Depends on nothing else.
package seg_pkg;

   // Item modes on the request side.
   localparam logic [1:0] MODE_BEGIN = 2'd0;
   localparam logic [1:0] MODE_NAME  = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;
   localparam logic [1:0] MODE_STOP  = 2'd3;

   // Packet flag byte values.
   localparam logic [1:0] FLAG_SINGLE = 2'd0;
   localparam logic [1:0] FLAG_FIRST  = 2'd1;
   localparam logic [1:0] FLAG_MIDDLE = 2'd2;
   localparam logic [1:0] FLAG_END    = 2'd3;

   // Configuration register.
   localparam int         CSR_W     = 10;
   localparam logic [9:0] CSR_RESET = 10'd244;
   localparam int         MTU_FLOOR = 20;

   // The first packet opens with flag, four size bytes and the name length.
   localparam int HEADER_BYTES = 6;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // Word counter inside one command in the back part.
   localparam int         STEP_W      = 3;
   localparam logic [2:0] HEADER_LAST = 3'd5;
   localparam logic [2:0] FLAG_LAST   = 3'd1;

   // Kind of work the back part carries out for one accepted item.
   typedef enum logic [3:0] {
      CMD_STATUS    = 4'b0001,
      CMD_HEADER    = 4'b0010,
      CMD_BYTE      = 4'b0100,
      CMD_FLAG_BYTE = 4'b1000
   } cmd_kind_type;

   // One queue entry: everything the back part needs to expand an item.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   head;
      logic [31:0]  size;
      logic [7:0]   tail;
      logic         packet_end;
      logic         transfer_done;
      logic         aborted;
      logic         rejected;
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       packet_end;
      logic       run_last;
      logic       transfer_done;
      logic       aborted;
      logic       rejected;
   } rsp_word_type;

endpackage

FILE: hdl/seg_front.sv
// Front part of the file packet segmenter: accepts items, tracks the transfer
// state and turns each item into one command for the back part.
// Depends on seg_pkg.
module seg_front #(
   parameter int MAX_PAYLOAD     = 514,
   parameter int MAX_NAME_LENGTH = 49
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [1:0]                req_mode,
   input  logic [31:0]               req_file_size,
   input  logic [5:0]                req_name_length,
   input  logic [7:0]                req_data_byte,
   input  logic                      queue_full,
   output logic                      cmd_push,
   output seg_pkg::cmd_type          cmd,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [seg_pkg::CSR_W-1:0] csr_data
);

   localparam int FILL_W = $clog2(MAX_PAYLOAD + 1);
   localparam int CMP_W  = (FILL_W > seg_pkg::CSR_W) ? FILL_W : seg_pkg::CSR_W;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_NAME = 3'b010,
      PHASE_DATA = 3'b100
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [1:0]                flag_ff, flag_in;
   logic [31:0]               remain_ff, remain_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [5:0]                name_left_ff, name_left_in;
   logic                      stop_ff, stop_in;
   logic [seg_pkg::CSR_W-1:0] csr_ff;

   logic [CMP_W-1:0]  csr_wide, mtu_wide;
   logic [FILL_W-1:0] mtu;
   logic [FILL_W-1:0] fill_inc;
   logic [5:0]        name_dec;
   logic [31:0]       remain_dec;
   logic              accept;
   logic              begin_bad;
   logic              fits_single;
   logic [1:0]        data_flag;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !queue_full;
   assign cmd_push  = accept;

   // Usable packet size, held within the supported range.
   always_comb begin
      csr_wide = CMP_W'(csr_ff);
      if (csr_wide > CMP_W'(MAX_PAYLOAD)) begin
         mtu_wide = CMP_W'(MAX_PAYLOAD);
      end else if (csr_wide < CMP_W'(seg_pkg::MTU_FLOOR)) begin
         mtu_wide = CMP_W'(seg_pkg::MTU_FLOOR);
      end else begin
         mtu_wide = csr_wide;
      end
      mtu = FILL_W'(mtu_wide);
   end

   assign fill_inc   = fill_ff + FILL_W'(1);
   assign name_dec   = name_left_ff - 6'd1;
   assign remain_dec = remain_ff - 32'd1;

   // A begin is refused if busy, its name too long or its header over a packet.
   assign begin_bad = (phase_ff != PHASE_IDLE)
                   || (req_name_length > 6'(MAX_NAME_LENGTH))
                   || ((CMP_W'(req_name_length) + CMP_W'(seg_pkg::HEADER_BYTES))
                       > mtu_wide);
   assign fits_single = ({1'b0, req_file_size} + 33'(req_name_length)
                         + 33'(seg_pkg::HEADER_BYTES)) <= 33'(mtu);
   assign data_flag = (remain_ff < 32'(mtu)) ? seg_pkg::FLAG_END : seg_pkg::FLAG_MIDDLE;

   // Classify the item, build its command and work out the next state.
   always_comb begin
      phase_in     = phase_ff;
      flag_in      = flag_ff;
      remain_in    = remain_ff;
      fill_in      = fill_ff;
      name_left_in = name_left_ff;
      stop_in      = stop_ff;

      cmd               = '0;
      cmd.kind          = seg_pkg::CMD_STATUS;
      cmd.size          = req_file_size;
      cmd.tail          = req_data_byte;

      case (req_mode)
         seg_pkg::MODE_BEGIN: begin
            if (begin_bad) begin
               cmd.rejected = 1'b1;
            end else begin
               flag_in      = fits_single ? seg_pkg::FLAG_SINGLE : seg_pkg::FLAG_FIRST;
               remain_in    = req_file_size;
               name_left_in = req_name_length;
               stop_in      = 1'b0;
               fill_in      = FILL_W'(seg_pkg::HEADER_BYTES);
               cmd.kind     = seg_pkg::CMD_HEADER;
               cmd.head     = {6'd0, flag_in};
               cmd.tail     = {2'd0, req_name_length};
               if (req_name_length != 6'd0) begin
                  phase_in = PHASE_NAME;
               end else if (req_file_size == 32'd0) begin
                  cmd.packet_end    = 1'b1;
                  cmd.transfer_done = 1'b1;
                  phase_in          = PHASE_IDLE;
                  fill_in           = '0;
               end else begin
                  phase_in = PHASE_DATA;
               end
            end
         end
         seg_pkg::MODE_NAME: begin
            if (phase_ff != PHASE_NAME || name_left_ff == 6'd0) begin
               cmd.rejected = 1'b1;
            end else begin
               cmd.kind     = seg_pkg::CMD_BYTE;
               fill_in      = fill_inc;
               name_left_in = name_dec;
               if (name_dec == 6'd0 && remain_ff == 32'd0) begin
                  cmd.packet_end    = 1'b1;
                  cmd.transfer_done = 1'b1;
                  phase_in          = PHASE_IDLE;
                  fill_in           = '0;
                  stop_in           = 1'b0;
               end else begin
                  if (name_dec == 6'd0) begin
                     phase_in = PHASE_DATA;
                  end
                  if (fill_inc >= mtu) begin
                     cmd.packet_end = 1'b1;
                     fill_in        = '0;
                  end
               end
            end
         end
         seg_pkg::MODE_DATA: begin
            if (phase_ff != PHASE_DATA || remain_ff == 32'd0) begin
               cmd.rejected = 1'b1;
            end else begin
               cmd.kind = seg_pkg::CMD_BYTE;
               fill_in  = fill_inc;
               // A new packet opens with its own flag byte.
               if (fill_ff == '0) begin
                  flag_in  = data_flag;
                  cmd.kind = seg_pkg::CMD_FLAG_BYTE;
                  cmd.head = {6'd0, data_flag};
                  fill_in  = FILL_W'(2);
               end
               remain_in = remain_dec;
               if (remain_dec == 32'd0) begin
                  cmd.packet_end    = 1'b1;
                  cmd.transfer_done = 1'b1;
                  phase_in          = PHASE_IDLE;
                  fill_in           = '0;
                  stop_in           = 1'b0;
               end else if (fill_in >= mtu) begin
                  cmd.packet_end = 1'b1;
                  fill_in        = '0;
                  if (flag_in == seg_pkg::FLAG_MIDDLE && stop_ff) begin
                     cmd.aborted = 1'b1;
                     phase_in    = PHASE_IDLE;
                     stop_in     = 1'b0;
                  end
               end
            end
         end
         seg_pkg::MODE_STOP: begin
            if (phase_ff != PHASE_IDLE) begin
               stop_in = 1'b1;
            end
         end
         default: begin
            cmd.rejected = 1'b1;
         end
      endcase
   end

   // Transfer state advances only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         flag_ff      <= seg_pkg::FLAG_SINGLE;
         remain_ff    <= '0;
         fill_ff      <= '0;
         name_left_ff <= '0;
         stop_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         remain_ff    <= remain_in;
         fill_ff      <= fill_in;
         name_left_ff <= name_left_in;
         stop_ff      <= stop_in;
      end
   end

   // Packet size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= seg_pkg::CSR_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_ff <= csr_data;
      end
   end

endmodule

FILE: hdl/seg_queue.sv
// Short command queue between the front and back parts of the segmenter.
// Depends on seg_pkg.
module seg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  seg_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output seg_pkg::cmd_type head_cmd,
   output logic             empty
);

   seg_pkg::cmd_type              entries_ff [seg_pkg::QUEUE_DEPTH];
   logic [seg_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [seg_pkg::QUEUE_PTR_W:0]   count_ff;
   logic                            do_push, do_pop;

   assign full     = (count_ff == (seg_pkg::QUEUE_PTR_W + 1)'(seg_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + (seg_pkg::QUEUE_PTR_W)'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + (seg_pkg::QUEUE_PTR_W)'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (seg_pkg::QUEUE_PTR_W + 1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (seg_pkg::QUEUE_PTR_W + 1)'(1);
         end
      end
   end

endmodule

FILE: hdl/seg_back.sv
// Back part of the segmenter: expands each queued command into result words,
// one word per cycle while the consumer pops, into its output register.
// Depends on seg_pkg.
module seg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  seg_pkg::cmd_type     cmd,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output seg_pkg::rsp_word_type rsp_word
);

   logic [seg_pkg::STEP_W-1:0] step_ff;
   logic                       valid_ff;
   seg_pkg::rsp_word_type      word_ff, word_in;
   logic                       last_step;
   logic                       load;

   assign rsp_empty = !valid_ff;
   assign rsp_word  = word_ff;
   assign load      = !cmd_empty && (!valid_ff || rsp_pop);
   assign cmd_pop   = load && last_step;

   // Pick the word for the current step of the command.
   always_comb begin
      word_in    = '0;
      last_step  = 1'b1;
      case (cmd.kind)
         seg_pkg::CMD_HEADER: begin
            last_step          = (step_ff == seg_pkg::HEADER_LAST);
            word_in.byte_valid = 1'b1;
            case (step_ff)
               3'd0:    word_in.out_byte = cmd.head;
               3'd1:    word_in.out_byte = cmd.size[31:24];
               3'd2:    word_in.out_byte = cmd.size[23:16];
               3'd3:    word_in.out_byte = cmd.size[15:8];
               3'd4:    word_in.out_byte = cmd.size[7:0];
               default: word_in.out_byte = cmd.tail;
            endcase
         end
         seg_pkg::CMD_FLAG_BYTE: begin
            last_step          = (step_ff == seg_pkg::FLAG_LAST);
            word_in.byte_valid = 1'b1;
            word_in.out_byte   = last_step ? cmd.tail : cmd.head;
         end
         seg_pkg::CMD_BYTE: begin
            word_in.byte_valid = 1'b1;
            word_in.out_byte   = cmd.tail;
         end
         default: begin
            word_in.rejected = cmd.rejected;
         end
      endcase
      // End-of-item flags ride on the last word only.
      if (last_step) begin
         word_in.run_last      = 1'b1;
         word_in.packet_end    = cmd.packet_end;
         word_in.transfer_done = cmd.transfer_done;
         word_in.aborted       = cmd.aborted;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   // Output valid and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            step_ff  <= last_step ? '0 : step_ff + (seg_pkg::STEP_W)'(1);
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: hdl/file_packet_segmenter.sv
// File packet segmenter: an item passes the command queue, then the output
// register. The front takes one item per cycle while the four-entry command
// queue has room; the back emits one word per cycle while the consumer pops:
// one for a file byte in a running packet, two for a byte opening a packet,
// six for a begin header. Reset is synchronous and clears the queue, the
// transfer state and sets the packet size register to 244.
module file_packet_segmenter #(
   parameter int MAX_PAYLOAD     = 514,
   parameter int MAX_NAME_LENGTH = 49
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_file_size,
   input  logic [5:0]  req_name_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_packet_end,
   output logic        rsp_run_last,
   output logic        rsp_transfer_done,
   output logic        rsp_aborted,
   output logic        rsp_rejected,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);

   seg_pkg::cmd_type      front_cmd, head_cmd;
   seg_pkg::rsp_word_type rsp_word;
   logic                  cmd_push, cmd_pop, queue_full, queue_empty;

   assign req_full = queue_full;

   // Item classification and transfer state.
   seg_front #(
      .MAX_PAYLOAD     (MAX_PAYLOAD),
      .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_mode        (req_mode),
      .req_file_size   (req_file_size),
      .req_name_length (req_name_length),
      .req_data_byte   (req_data_byte),
      .queue_full      (queue_full),
      .cmd_push        (cmd_push),
      .cmd             (front_cmd),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // Decoupling queue.
   seg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   // Word emitter with output register.
   seg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_empty (queue_empty),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_byte      = rsp_word.out_byte;
   assign rsp_byte_valid    = rsp_word.byte_valid;
   assign rsp_packet_end    = rsp_word.packet_end;
   assign rsp_run_last      = rsp_word.run_last;
   assign rsp_transfer_done = rsp_word.transfer_done;
   assign rsp_aborted       = rsp_word.aborted;
   assign rsp_rejected      = rsp_word.rejected;

endmodule

FILE: hdl/seg_checker.sv
// Port-level checks for the file packet segmenter, bound to the top level.
// Depends on the top-level port list only.
module seg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_packet_end,
   input logic        rsp_run_last,
   input logic        rsp_transfer_done,
   input logic        rsp_aborted,
   input logic        rsp_rejected
);

   // After reset nothing waits on the result side and items are taken.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("segmenter not empty after reset");

   // A waiting word holds until it is popped.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte)
                                 && $stable(rsp_run_last))
      else $error("waiting word changed");

   // A status word carries a zero byte and closes its item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_byte_valid |-> rsp_out_byte == 8'd0 && rsp_run_last
                                        && !rsp_packet_end)
      else $error("malformed status word");

   // A refused item gives a status word only.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_rejected |-> !rsp_byte_valid)
      else $error("rejected word carries a byte");

   // Done and abort land on a packet end, never both.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_transfer_done || rsp_aborted)
         |-> rsp_packet_end && rsp_byte_valid && rsp_run_last
             && !(rsp_transfer_done && rsp_aborted))
      else $error("transfer end flags inconsistent");

endmodule

bind file_packet_segmenter seg_checker u_seg_checker (.*);

FILE: sim/tb_file_packet_segmenter.sv
// Self-checking testbench for the file packet segmenter: a predictor tracks the
// transfer state and queues the expected packet words, a checker compares each popped word.
// Depends on seg_pkg and file_packet_segmenter from the hdl folder.
`timescale 1ns / 100ps

module tb_file_packet_segmenter;

   localparam int MAX_PAYLOAD     = 514;
   localparam int MAX_NAME_LENGTH = 49;
   localparam int CYCLE_LIMIT     = 1000000;

   // Transfer phase as the predictor sees it.
   typedef enum logic [2:0] {
      XFER_IDLE = 3'b001,
      XFER_NAME = 3'b010,
      XFER_DATA = 3'b100
   } xfer_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_mode = seg_pkg::MODE_STOP;
   logic [31:0] req_file_size = '0;
   logic [5:0]  req_name_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_packet_end;
   logic        rsp_run_last;
   logic        rsp_transfer_done;
   logic        rsp_aborted;
   logic        rsp_rejected;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data = '0;

   // Predictor state, mirroring the block after reset.
   logic [9:0]     mtu_reg = seg_pkg::CSR_RESET;
   xfer_phase_type xfer_phase = XFER_IDLE;
   logic [31:0]    bytes_left = '0;
   logic [5:0]     name_left = '0;
   logic [1:0]     xfer_flag = seg_pkg::FLAG_SINGLE;
   logic           stop_pending = 1'b0;
   int unsigned    packet_fill = 0;

   seg_pkg::rsp_word_type expected_words[$];
   int fail_count = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int pop_stall_pct = 0;
   int hold_request = 0;

   file_packet_segmenter #(
      .MAX_PAYLOAD     (MAX_PAYLOAD),
      .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_file_size     (req_file_size),
      .req_name_length   (req_name_length),
      .req_data_byte     (req_data_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_packet_end    (rsp_packet_end),
      .rsp_run_last      (rsp_run_last),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_aborted       (rsp_aborted),
      .rsp_rejected      (rsp_rejected),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Packet size in use: the register clamped to the legal range.
   function automatic int unsigned effective_mtu();
      if (mtu_reg < seg_pkg::MTU_FLOOR) return seg_pkg::MTU_FLOOR;
      if (mtu_reg > MAX_PAYLOAD) return MAX_PAYLOAD;
      return mtu_reg;
   endfunction

   function automatic seg_pkg::rsp_word_type make_word(logic [7:0] value, logic valid,
                                                       logic rej);
      seg_pkg::rsp_word_type w;
      w = '0;
      w.out_byte   = value;
      w.byte_valid = valid;
      w.rejected   = rej;
      return w;
   endfunction

   function void close_transfer();
      xfer_phase   = XFER_IDLE;
      packet_fill  = 0;
      stop_pending = 1'b0;
   endfunction

   // Works out the packet words one accepted item produces and queues them.
   function automatic void predict_packet_bytes(logic [1:0] mode, logic [31:0] size,
                                                logic [5:0] nlen, logic [7:0] data);
      seg_pkg::rsp_word_type words[$];
      seg_pkg::rsp_word_type w;
      int unsigned           mtu;
      logic [63:0]           total;
      mtu = effective_mtu();
      case (mode)
         seg_pkg::MODE_BEGIN: begin
            if (xfer_phase != XFER_IDLE || nlen > MAX_NAME_LENGTH
                || seg_pkg::HEADER_BYTES + nlen > mtu) begin
               words.push_back(make_word(8'h00, 1'b0, 1'b1));
            end else begin
               total        = 64'(size) + 64'(nlen) + 64'(seg_pkg::HEADER_BYTES);
               xfer_flag    = (total <= 64'(mtu)) ? seg_pkg::FLAG_SINGLE
                                                  : seg_pkg::FLAG_FIRST;
               bytes_left   = size;
               name_left    = nlen;
               stop_pending = 1'b0;
               words.push_back(make_word({6'd0, xfer_flag}, 1'b1, 1'b0));
               words.push_back(make_word(size[31:24], 1'b1, 1'b0));
               words.push_back(make_word(size[23:16], 1'b1, 1'b0));
               words.push_back(make_word(size[15:8], 1'b1, 1'b0));
               words.push_back(make_word(size[7:0], 1'b1, 1'b0));
               words.push_back(make_word({2'b00, nlen}, 1'b1, 1'b0));
               packet_fill = seg_pkg::HEADER_BYTES;
               if (nlen != 0) begin
                  xfer_phase = XFER_NAME;
               end else if (size == 0) begin
                  // An empty file with no name is done on the length byte.
                  w = words.pop_back();
                  w.packet_end    = 1'b1;
                  w.transfer_done = 1'b1;
                  words.push_back(w);
                  close_transfer();
               end else begin
                  xfer_phase = XFER_DATA;
               end
            end
         end
         seg_pkg::MODE_NAME: begin
            if (xfer_phase != XFER_NAME || name_left == 0) begin
               words.push_back(make_word(8'h00, 1'b0, 1'b1));
            end else begin
               w = make_word(data, 1'b1, 1'b0);
               packet_fill++;
               name_left--;
               if (name_left == 0 && bytes_left == 0) begin
                  w.packet_end    = 1'b1;
                  w.transfer_done = 1'b1;
                  close_transfer();
               end else begin
                  if (name_left == 0) xfer_phase = XFER_DATA;
                  if (packet_fill >= mtu) begin
                     w.packet_end = 1'b1;
                     packet_fill  = 0;
                  end
               end
               words.push_back(w);
            end
         end
         seg_pkg::MODE_DATA: begin
            if (xfer_phase != XFER_DATA || bytes_left == 0) begin
               words.push_back(make_word(8'h00, 1'b0, 1'b1));
            end else begin
               // A byte that opens a packet is preceded by its flag byte.
               if (packet_fill == 0) begin
                  xfer_flag = (bytes_left <= 32'(mtu - 1)) ? seg_pkg::FLAG_END
                                                           : seg_pkg::FLAG_MIDDLE;
                  words.push_back(make_word({6'd0, xfer_flag}, 1'b1, 1'b0));
                  packet_fill = 1;
               end
               w = make_word(data, 1'b1, 1'b0);
               packet_fill++;
               bytes_left--;
               if (bytes_left == 0) begin
                  w.packet_end    = 1'b1;
                  w.transfer_done = 1'b1;
                  close_transfer();
               end else if (packet_fill >= mtu) begin
                  w.packet_end = 1'b1;
                  packet_fill  = 0;
                  // A pending stop takes effect only at the end of a middle packet.
                  if (xfer_flag == seg_pkg::FLAG_MIDDLE && stop_pending) begin
                     w.aborted = 1'b1;
                     close_transfer();
                  end
               end
               words.push_back(w);
            end
         end
         default: begin
            if (xfer_phase != XFER_IDLE) stop_pending = 1'b1;
            words.push_back(make_word(8'h00, 1'b0, 1'b0));
         end
      endcase
      w = words.pop_back();
      w.run_last = 1'b1;
      words.push_back(w);
      foreach (words[i]) expected_words.push_back(words[i]);
   endfunction

   function void report_word(string what, seg_pkg::rsp_word_type want,
                             seg_pkg::rsp_word_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s: expected %h v%0b pe%0b rl%0b td%0b ab%0b rj%0b",
                  what, want.out_byte, want.byte_valid, want.packet_end, want.run_last,
                  want.transfer_done, want.aborted, want.rejected);
         $display("   actual %h v%0b pe%0b rl%0b td%0b ab%0b rj%0b",
                  got.out_byte, got.byte_valid, got.packet_end, got.run_last,
                  got.transfer_done, got.aborted, got.rejected);
      end
   endfunction

   // Each popped word is compared with the oldest expected word.
   always @(posedge clock) begin : check_words
      seg_pkg::rsp_word_type got;
      seg_pkg::rsp_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_out_byte, rsp_byte_valid, rsp_packet_end, rsp_run_last,
                rsp_transfer_done, rsp_aborted, rsp_rejected};
         if (expected_words.size() == 0) begin
            report_word("unexpected word", '0, got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) report_word("word mismatch", want, got);
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request.
   initial begin : drive_pop
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   // Offers one item, with random gaps ahead of it, and returns once it is taken.
   task automatic send_item(input logic [1:0] mode, input logic [31:0] size,
                            input logic [5:0] nlen, input logic [7:0] data);
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_mode        <= mode;
      req_file_size   <= size;
      req_name_length <= nlen;
      req_data_byte   <= data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_packet_bytes(mode, size, nlen, data);
      items_sent++;
   endtask

   task automatic send_data_byte(input logic [7:0] data);
      send_item(seg_pkg::MODE_DATA, $urandom, 6'($urandom_range(63)), data);
   endtask

   task automatic send_name_byte(input logic [7:0] data);
      send_item(seg_pkg::MODE_NAME, $urandom, 6'($urandom_range(63)), data);
   endtask

   // Stops offering items until every expected word has been popped.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mtu(input logic [9:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mtu_reg = value;
   endtask

   // Random item of any mode; a begin while idle always has an oversized name.
   task automatic send_noise_item();
      logic [1:0] mode;
      logic [5:0] nlen;
      mode = 2'($urandom_range(3));
      if (mode == seg_pkg::MODE_BEGIN && xfer_phase == XFER_IDLE)
         nlen = 6'($urandom_range(63, MAX_NAME_LENGTH + 1));
      else
         nlen = 6'($urandom_range(63));
      send_item(mode, $urandom, nlen, 8'($urandom_range(255)));
   endtask

   // One well-formed transfer with random content, sometimes cut short by a stop.
   task automatic send_transfer();
      int unsigned mtu;
      int unsigned nlen;
      int unsigned pick;
      logic [31:0] size;
      int          stop_at;
      int          sent;
      mtu  = effective_mtu();
      nlen = ($urandom_range(7) == 0) ? $urandom_range(MAX_NAME_LENGTH) : $urandom_range(4);
      if (nlen + seg_pkg::HEADER_BYTES > mtu) nlen = mtu - seg_pkg::HEADER_BYTES;
      pick = $urandom_range(19);
      if (pick < 12) size = $urandom_range(40);
      else if (pick < 17) size = $urandom_range(120);
      else if (mtu <= 128) size = $urandom;
      else size = $urandom_range(mtu + 40);
      // Huge files only end through a stop, which lands within the first packets.
      if (size > 2000) stop_at = $urandom_range(mtu);
      else if ($urandom_range(3) == 0) stop_at = $urandom_range(size);
      else stop_at = -1;
      send_item(seg_pkg::MODE_BEGIN, size, 6'(nlen), 8'($urandom_range(255)));
      while (xfer_phase == XFER_NAME) send_name_byte(8'($urandom_range(255)));
      sent = 0;
      while (xfer_phase == XFER_DATA) begin
         if (sent == stop_at)
            send_item(seg_pkg::MODE_STOP, $urandom, 6'($urandom_range(63)), 8'h00);
         if ($urandom_range(29) == 0) send_noise_item();
         if (xfer_phase == XFER_DATA) send_data_byte(8'($urandom_range(255)));
         sent++;
      end
   endtask

   // Status items, rejections, the smallest transfers and stops that arrive too late.
   task automatic test_directed_items();
      send_item(seg_pkg::MODE_STOP, 32'h0, 6'd0, 8'h00);
      send_name_byte(8'h41);
      send_data_byte(8'h42);
      send_item(seg_pkg::MODE_BEGIN, 32'h0, 6'd63, 8'h00);
      send_item(seg_pkg::MODE_BEGIN, 32'hFFFF_FFFF, 6'd50, 8'h00);
      send_item(seg_pkg::MODE_BEGIN, 32'h0, 6'd0, 8'h00);
      send_item(seg_pkg::MODE_BEGIN, 32'h0, 6'd1, 8'h00);
      send_name_byte(8'hFF);
      send_item(seg_pkg::MODE_BEGIN, 32'd2, 6'd1, 8'h00);
      send_item(seg_pkg::MODE_BEGIN, 32'd5, 6'd0, 8'h00);
      send_data_byte(8'h11);
      send_name_byte(8'h00);
      send_name_byte(8'h22);
      send_item(seg_pkg::MODE_STOP, 32'hFFFF_FFFF, 6'd63, 8'hFF);
      send_data_byte(8'hA5);
      send_data_byte(8'h5A);
      send_item(seg_pkg::MODE_BEGIN, 32'd1, 6'd0, 8'h00);
      send_data_byte(8'hFF);
      send_data_byte(8'h00);
      wait_drained();
   endtask

   // Register at both clamps: header limits and names that fill a whole packet.
   task automatic test_register_extremes();
      write_mtu(10'd0);
      send_item(seg_pkg::MODE_BEGIN, 32'd0, 6'd15, 8'h00);
      send_item(seg_pkg::MODE_BEGIN, 32'd0, 6'd14, 8'h00);
      while (xfer_phase != XFER_IDLE) send_name_byte(8'($urandom_range(255)));
      send_item(seg_pkg::MODE_BEGIN, 32'd5, 6'd14, 8'h00);
      while (xfer_phase == XFER_NAME) send_name_byte(8'($urandom_range(255)));
      while (xfer_phase == XFER_DATA) send_data_byte(8'($urandom_range(255)));
      wait_drained();
      write_mtu(10'h3FF);
      send_item(seg_pkg::MODE_BEGIN, 32'd0, 6'(MAX_NAME_LENGTH), 8'h00);
      while (xfer_phase != XFER_IDLE) send_name_byte(8'($urandom_range(255)));
      wait_drained();
      write_mtu(10'(MAX_PAYLOAD));
      wait_drained();
   endtask

   // A stop aborts at the end of a middle packet but is dropped when the end packet finishes.
   task automatic test_stop_abort();
      write_mtu(10'd20);
      send_item(seg_pkg::MODE_BEGIN, 32'hFFFF_FFFF, 6'd2, 8'h00);
      send_name_byte(8'h00);
      send_name_byte(8'hFF);
      send_item(seg_pkg::MODE_STOP, 32'h0, 6'd0, 8'h00);
      while (xfer_phase != XFER_IDLE) send_data_byte(8'($urandom_range(255)));
      send_data_byte(8'h33);
      send_item(seg_pkg::MODE_BEGIN, 32'd25, 6'd0, 8'h00);
      repeat (14) send_data_byte(8'($urandom_range(255)));
      send_item(seg_pkg::MODE_STOP, 32'h0, 6'd0, 8'h00);
      while (xfer_phase != XFER_IDLE) send_data_byte(8'($urandom_range(255)));
      send_item(seg_pkg::MODE_BEGIN, 32'd3, 6'd0, 8'h00);
      while (xfer_phase != XFER_IDLE) send_data_byte(8'($urandom_range(255)));
      wait_drained();
   endtask

   // Packet size lowered in the middle of a packet that is already longer.
   task automatic test_mtu_lowered();
      write_mtu(10'd40);
      send_item(seg_pkg::MODE_BEGIN, 32'd60, 6'd0, 8'h00);
      repeat (30) send_data_byte(8'($urandom_range(255)));
      wait_drained();
      write_mtu(10'd20);
      while (xfer_phase != XFER_IDLE) send_data_byte(8'($urandom_range(255)));
      wait_drained();
      write_mtu(seg_pkg::CSR_RESET);
   endtask

   // Result side held off for a long stretch while a transfer keeps coming.
   task automatic test_backpressure();
      hold_request = 400;
      send_item(seg_pkg::MODE_BEGIN, 32'd30, 6'd3, 8'h00);
      while (xfer_phase != XFER_IDLE) begin
         if (xfer_phase == XFER_NAME) send_name_byte(8'($urandom_range(255)));
         else send_data_byte(8'($urandom_range(255)));
      end
      wait_drained();
   endtask

   // Mostly well-formed transfers with some noise, under one idling pattern.
   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input logic [9:0] mtu_value, input int item_count);
      int first_item;
      send_gap_pct  = gap_pct;
      pop_stall_pct = stall_pct;
      write_mtu(mtu_value);
      first_item = items_sent;
      while (items_sent - first_item < item_count) begin
         if ($urandom_range(9) == 0) send_noise_item();
         else send_transfer();
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_items();
      test_register_extremes();
      test_stop_abort();
      test_mtu_lowered();
      test_backpressure();
      test_random_traffic(0, 0, 10'd20, 40);
      test_random_traffic(67, 0, 10'(MAX_PAYLOAD), 40);
      test_random_traffic(0, 67, 10'($urandom_range(120, 20)), 40);
      test_random_traffic(10, 10, 10'($urandom_range(MAX_PAYLOAD, 20)), 40);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
